>>> hdl/ir_micro_op_executor_defines.svh
// Assertion macros for the micro-op executor checker.
// Expects signals named clock and reset in the scope of use.
`ifndef IR_MICRO_OP_EXECUTOR_DEFINES_SVH
`define IR_MICRO_OP_EXECUTOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define IME_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every clock edge, reset included.
`define IME_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> hdl/ime_pkg.sv
// Package for the micro-op executor: op codes, constants, the back-end state type and the queued item type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ime_pkg;

   typedef enum logic [5:0] {
      OP_LOAD_REG     = 6'd0,
      OP_STORE_REG    = 6'd1,
      OP_LOAD_FLAG    = 6'd2,
      OP_STORE_FLAG   = 6'd3,
      OP_LOAD_STATUS  = 6'd4,
      OP_STORE_STATUS = 6'd5,
      OP_LOAD_SAVED   = 6'd6,
      OP_STORE_SAVED  = 6'd7,
      OP_NOP          = 6'd8,
      OP_MOV          = 6'd9,
      OP_AND          = 6'd10,
      OP_OR           = 6'd11,
      OP_XOR          = 6'd12,
      OP_NOT          = 6'd13,
      OP_LSL          = 6'd14,
      OP_LSR          = 6'd15,
      OP_ASR          = 6'd16,
      OP_ROR          = 6'd17,
      OP_RRC          = 6'd18,
      OP_ADD          = 6'd19,
      OP_SUB          = 6'd20,
      OP_ADC          = 6'd21,
      OP_SBC          = 6'd22,
      OP_MUL          = 6'd23,
      OP_UMULH        = 6'd24,
      OP_SMULH        = 6'd25,
      OP_CLZ          = 6'd26,
      OP_GETN         = 6'd27,
      OP_GETZ         = 6'd28,
      OP_GETC         = 6'd29,
      OP_GETV         = 6'd30,
      OP_SETC         = 6'd31,
      OP_GETCIFZ      = 6'd32,
      OP_PCMASK       = 6'd33,
      OP_JZ           = 6'd34,
      OP_JNZ          = 6'd35,
      OP_BEGIN        = 6'd36,
      OP_END          = 6'd37
   } ime_op_type;

   localparam logic [5:0]  OP_LAST     = 6'd37;
   localparam int          IDX_MAX_W   = 16;
   localparam logic [31:0] PCMASK_ARM  = ~32'd1;
   localparam logic [31:0] PCMASK_WORD = ~32'd3;

   typedef enum logic {
      BK_ISSUE = 1'b0,
      BK_EXEC  = 1'b1
   } ime_back_state_type;

   typedef struct packed {
      ime_op_type           op;
      logic                 has_result;
      logic [IDX_MAX_W-1:0] dest;
      logic [31:0]          a_val;
      logic                 a_imm;
      logic [31:0]          b_val;
      logic                 b_imm;
   } ime_item_type;

endpackage

`default_nettype wire

>>> hdl/ir_micro_op_executor.sv
// An accepted transaction is queued, popped into the back end with its value-file reads, then
// executed into the result register. The back end takes no new item until the last one has
// executed and written back; a held response stalls it. A two-entry queue buffers the front end.
// Reset is synchronous and active high; it clears the queue, the sequencer, the result
// register, the sixteen registers, both status words and the carry and overflow flags.
// The value file is not cleared; VALUE_DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module ir_micro_op_executor
   import ime_pkg::*;
#(
   parameter int VALUE_DEPTH = 1024
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // dest_index[9:0], first_operand[41:10], second_operand[73:42], zero pad[79:74]
   input  wire logic [79:0]  req_tdata,
   // action[5:0], first_is_immediate[6], second_is_immediate[7]
   input  wire logic [7:0]   req_tuser,
   // Response channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_value[31:0], branch_distance[63:32]
   output logic [63:0]       rsp_tdata,
   // branch_taken[0]
   output logic              rsp_tuser,
   // block_done
   output logic              rsp_tlast
);

   // The front end decodes each transaction and queues it; the back end pops
   // one item, reads both operands from the value file into registers, then
   // executes, updates state and loads the result register. The
   // next item's read therefore always sees the previous item's write.
   ime_item_type q_item;
   logic         q_valid;
   logic         q_pop;

   ime_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop)
   );

   ime_back #(
      .VALUE_DEPTH (VALUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> hdl/ime_front.sv
// Front end of the micro-op executor: accepts transactions, decodes the op
// and holds decoded items in a two-entry queue. Depends on ime_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ime_front
   import ime_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [79:0]  req_tdata,
   input  wire logic [7:0]   req_tuser,
   output ime_item_type      q_item,
   output logic              q_valid,
   input  wire logic         q_pop
);

   ime_item_type item_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff, count_in;
   ime_item_type dec;
   logic         push, pop;

   always_comb begin
      dec.op = OP_NOP;
      if (req_tuser[5:0] <= OP_LAST) begin
         dec.op = ime_op_type'(req_tuser[5:0]);
      end
      dec.has_result = !(dec.op inside {OP_STORE_REG, OP_STORE_FLAG, OP_STORE_STATUS,
                                        OP_STORE_SAVED, OP_NOP, OP_SETC, OP_JZ, OP_JNZ,
                                        OP_BEGIN, OP_END});
      dec.dest  = IDX_MAX_W'(req_tdata[9:0]);
      dec.a_val = req_tdata[41:10];
      dec.a_imm = req_tuser[6];
      dec.b_val = req_tdata[73:42];
      dec.b_imm = req_tuser[7];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_item     = item_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

>>> hdl/ime_back.sv
// Back end of the micro-op executor: value-file memory, architectural state,
// the execute datapath and the result register. Depends on ime_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ime_back
   import ime_pkg::*;
#(
   parameter int VALUE_DEPTH = 1024
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ime_item_type q_item,
   input  wire logic         q_valid,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   localparam int IDX_W = $clog2(VALUE_DEPTH);

   logic [31:0]        vf_mem [VALUE_DEPTH];
   logic [31:0]        rd_a_ff, rd_b_ff;
   ime_item_type       item_ff;
   ime_back_state_type state_ff, state_in;
   logic [31:0]        regs_ff [16];
   logic [31:0]        status_ff, saved_ff;
   logic               carry_ff, ovf_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_res_ff, rsp_dist_ff;
   logic               rsp_taken_ff, rsp_done_ff;
   logic               fire;

   logic [31:0]        a, b, bit_sel, res, jump_dist, b_add;
   logic               taken, cin, sum_ovf;
   logic [32:0]        sum;
   logic [4:0]         asr_sh;
   logic [63:0]        rot;
   logic               sext;
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic [5:0]         clz;

   // Sequencer: an issue state pops an item and reads the value file, then an execute state runs it.
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      fire     = 1'b0;
      case (state_ff)
         BK_ISSUE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               fire     = 1'b1;
               state_in = BK_ISSUE;
            end
         end
         default: state_in = BK_ISSUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_ISSUE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
         rd_a_ff <= vf_mem[q_item.a_val[IDX_W-1:0]];
         rd_b_ff <= vf_mem[q_item.b_val[IDX_W-1:0]];
      end
      if (fire && item_ff.has_result) begin
         vf_mem[item_ff.dest[IDX_W-1:0]] <= res;
      end
   end

   assign a       = item_ff.a_imm ? item_ff.a_val : rd_a_ff;
   assign b       = item_ff.b_imm ? item_ff.b_val : rd_b_ff;
   assign bit_sel = 32'd1 << (5'd31 - a[4:0]);

   // Shared adder for the add family.
   always_comb begin
      b_add = b;
      cin   = 1'b0;
      case (item_ff.op)
         OP_SUB:  begin b_add = ~b; cin = 1'b1;     end
         OP_ADC:  begin b_add = b;  cin = carry_ff; end
         OP_SBC:  begin b_add = ~b; cin = carry_ff; end
         default: begin b_add = b;  cin = 1'b0;     end
      endcase
   end

   assign sum     = 33'(a) + 33'(b_add) + 33'(cin);
   assign sum_ovf = (a[31] ^ sum[31]) & ~(a[31] ^ b_add[31]);

   // One 33x33 signed multiplier serves the low, unsigned-high and signed-high forms.
   assign sext = (item_ff.op == OP_SMULH);
   assign ma   = $signed({sext & a[31], a});
   assign mb   = $signed({sext & b[31], b});
   assign prod = ma * mb;

   assign asr_sh = (b[31:5] != 27'd0) ? 5'd31 : b[4:0];
   assign rot    = {a, a} >> b[4:0];

   always_comb begin
      clz = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (b[i]) begin
            clz = 6'(31 - i);
         end
      end
   end

   always_comb begin
      res       = 32'd0;
      taken     = 1'b0;
      jump_dist = 32'd0;
      case (item_ff.op)
         OP_LOAD_REG:    res = regs_ff[a[3:0]];
         OP_LOAD_FLAG:   res = 32'((status_ff & bit_sel) != 32'd0);
         OP_LOAD_STATUS: res = status_ff;
         OP_LOAD_SAVED:  res = saved_ff;
         OP_MOV:         res = b;
         OP_AND:         res = a & b;
         OP_OR:          res = a | b;
         OP_XOR:         res = a ^ b;
         OP_NOT:         res = ~b;
         OP_LSL:         res = (b[31:5] != 27'd0) ? 32'd0 : (a << b[4:0]);
         OP_LSR:         res = (b[31:5] != 27'd0) ? 32'd0 : (a >> b[4:0]);
         OP_ASR:         res = 32'($signed(a) >>> asr_sh);
         OP_ROR:         res = rot[31:0];
         OP_RRC:         res = {carry_ff, a[31:1]};
         OP_ADD, OP_SUB, OP_ADC, OP_SBC: res = sum[31:0];
         OP_MUL:         res = prod[31:0];
         OP_UMULH, OP_SMULH: res = prod[63:32];
         OP_CLZ:         res = 32'(clz);
         OP_GETN:        res = 32'(b[31]);
         OP_GETZ:        res = 32'(b == 32'd0);
         OP_GETC:        res = 32'(carry_ff);
         OP_GETV:        res = 32'(ovf_ff);
         OP_GETCIFZ:     res = (a != 32'd0) ? b : 32'(carry_ff);
         OP_PCMASK:      res = (a != 32'd0) ? PCMASK_ARM : PCMASK_WORD;
         OP_JZ: begin
            taken     = (a == 32'd0);
            jump_dist = taken ? b : 32'd0;
         end
         OP_JNZ: begin
            taken     = (a != 32'd0);
            jump_dist = taken ? b : 32'd0;
         end
         default: res = 32'd0;
      endcase
   end

   // Architectural state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            regs_ff[i] <= 32'd0;
         end
         status_ff <= 32'd0;
         saved_ff  <= 32'd0;
         carry_ff  <= 1'b0;
         ovf_ff    <= 1'b0;
      end else if (fire) begin
         case (item_ff.op)
            OP_STORE_REG:    regs_ff[a[3:0]] <= b;
            OP_STORE_FLAG:   status_ff <= (b != 32'd0) ? (status_ff | bit_sel)
                                                       : (status_ff & ~bit_sel);
            OP_STORE_STATUS: status_ff <= b;
            OP_STORE_SAVED:  saved_ff  <= b;
            OP_SETC:         carry_ff  <= (b != 32'd0);
            OP_ADD, OP_SUB, OP_ADC, OP_SBC: begin
               carry_ff <= sum[32];
               ovf_ff   <= sum_ovf;
            end
            default: ;
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_res_ff   <= res;
         rsp_dist_ff  <= jump_dist;
         rsp_taken_ff <= taken;
         rsp_done_ff  <= (item_ff.op == OP_END);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dist_ff, rsp_res_ff};
   assign rsp_tuser  = rsp_taken_ff;
   assign rsp_tlast  = rsp_done_ff;

endmodule

`default_nettype wire

>>> hdl/ime_checker.sv
// Port-level checks for the micro-op executor, bound to the top level.
// Depends on ir_micro_op_executor_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ir_micro_op_executor_defines.svh"

module ime_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // The end op carries no result and no jump.
   `IME_ASSERT(a_done_clean, rsp_tvalid && rsp_tlast |-> rsp_tdata == 64'd0 && !rsp_tuser, "end op has payload")
   // A taken jump writes no result.
   `IME_ASSERT(a_jump_no_result, rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == 32'd0, "jump has result")
   // A not-taken transaction reports no distance.
   `IME_ASSERT(a_no_stray_dist, rsp_tvalid && !rsp_tuser |-> rsp_tdata[63:32] == 32'd0, "stray distance")
   // A stalled response holds.
   `IME_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response dropped")
   // Reset empties the response register.
   `IME_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind ir_micro_op_executor ime_checker u_ime_checker (.*);

`default_nettype wire
